// ----- design/lightmap_color_adjust_defines.svh -----
// Assertion macros used by the lightmap color adjust top level.
`ifndef LIGHTMAP_COLOR_ADJUST_DEFINES_SVH
`define LIGHTMAP_COLOR_ADJUST_DEFINES_SVH

`ifndef SYNTH
`define LCA_ASSERT_IMPL(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("assertion failed");
`define LCA_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("assertion failed");
`else
`define LCA_ASSERT_IMPL(label, clk, rst, cond, conseq)
`define LCA_ASSERT_NEXT(label, clk, rst, cond, conseq)
`endif

`endif

// ----- design/lca_pkg.sv -----
// Shared types, widths and constants of the lightmap color adjust block.
package lca_pkg;

   localparam int CHANNEL_WIDTH  = 24;
   localparam int FRAC_BITS      = 8;
   localparam int SCALED_WIDTH   = CHANNEL_WIDTH + 9;
   localparam int DIV_STEPS      = 16;
   localparam int NUMER_WIDTH    = SCALED_WIDTH + DIV_STEPS;
   localparam int LEVEL_WIDTH    = 16;
   localparam int LUMA_WIDTH     = LEVEL_WIDTH + 2;
   localparam int CSR_WIDTH      = 16;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int NUM_LANES      = 3;

   localparam logic [LEVEL_WIDTH-1:0] NORM_LIMIT = 16'hFF00;

   localparam logic [2:0] IDX_ADD_OFFSET    = 3'd0;
   localparam logic [2:0] IDX_GAIN          = 3'd1;
   localparam logic [2:0] IDX_SAT_FACTOR    = 3'd2;
   localparam logic [2:0] IDX_LUMA_WEIGHT_R = 3'd3;
   localparam logic [2:0] IDX_LUMA_WEIGHT_G = 3'd4;
   localparam logic [2:0] IDX_LUMA_WEIGHT_B = 3'd5;

   localparam logic [CSR_WIDTH-1:0] RST_ADD_OFFSET    = 16'd0;
   localparam logic [CSR_WIDTH-1:0] RST_GAIN          = 16'd256;
   localparam logic [CSR_WIDTH-1:0] RST_SAT_FACTOR    = 16'd256;
   localparam logic [CSR_WIDTH-1:0] RST_LUMA_WEIGHT_R = 16'd19595;
   localparam logic [CSR_WIDTH-1:0] RST_LUMA_WEIGHT_G = 16'd38470;
   localparam logic [CSR_WIDTH-1:0] RST_LUMA_WEIGHT_B = 16'd7471;

   typedef struct packed {
      logic [CHANNEL_WIDTH-1:0] red_in;
      logic [CHANNEL_WIDTH-1:0] green_in;
      logic [CHANNEL_WIDTH-1:0] blue_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [CSR_WIDTH-1:0] add_offset;
      logic [CSR_WIDTH-1:0]        gain;
      logic [CSR_WIDTH-1:0]        sat_factor;
      logic [CSR_WIDTH-1:0]        luma_weight_r;
      logic [CSR_WIDTH-1:0]        luma_weight_g;
      logic [CSR_WIDTH-1:0]        luma_weight_b;
   } csr_type;

endpackage

// ----- design/lca_scale_lane.sv -----
// One channel lane: offset, gain, floor to Q.8 and clamp of negatives to zero.
module lca_scale_lane (
   input  logic                                clock,
   input  logic                                load,
   input  logic [lca_pkg::CHANNEL_WIDTH-1:0]   chan,
   input  logic signed [lca_pkg::CSR_WIDTH-1:0] offset,
   input  logic [lca_pkg::CSR_WIDTH-1:0]       gain,
   output logic [lca_pkg::SCALED_WIDTH-1:0]    level_out
);
   import lca_pkg::*;

   localparam int SUM_W  = CHANNEL_WIDTH + 2;
   localparam int PROD_W = SUM_W + CSR_WIDTH + 1;

   logic signed [SUM_W-1:0]  sum;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] shifted;
   logic [SCALED_WIDTH-1:0]  level_in;
   logic [SCALED_WIDTH-1:0]  level_ff;

   always_comb begin
      sum      = $signed({2'b00, chan}) + SUM_W'(offset);
      prod     = sum * $signed({1'b0, gain});
      shifted  = prod >>> FRAC_BITS;
      level_in = shifted[PROD_W-1] ? '0 : shifted[SCALED_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         level_ff <= level_in;
      end
   end

   assign level_out = level_ff;

endmodule

// ----- design/lca_div_lane.sv -----
// One channel lane of the pipelined restoring divider that scales by 65280 / peak.
module lca_div_lane (
   input  logic                             clock,
   input  logic [lca_pkg::DIV_STEPS:0]      load,
   input  logic [lca_pkg::SCALED_WIDTH-1:0] level,
   input  logic [lca_pkg::SCALED_WIDTH-1:0] peak,
   input  logic                             norm,
   output logic [lca_pkg::LEVEL_WIDTH-1:0]  level_out
);
   import lca_pkg::*;

   logic [NUMER_WIDTH-1:0]  numer;
   logic [SCALED_WIDTH-1:0] rem_ff  [DIV_STEPS+1];
   logic [DIV_STEPS-1:0]    low_ff  [DIV_STEPS+1];
   logic [DIV_STEPS-1:0]    quo_ff  [DIV_STEPS+1];
   logic [SCALED_WIDTH-1:0] peak_ff [DIV_STEPS+1];
   logic                    norm_ff [DIV_STEPS+1];
   logic [LEVEL_WIDTH-1:0]  pass_ff [DIV_STEPS+1];

   assign numer = {level, {DIV_STEPS{1'b0}}} - NUMER_WIDTH'({level, {FRAC_BITS{1'b0}}});

   always_ff @(posedge clock) begin
      if (load[0]) begin
         rem_ff[0]  <= numer[NUMER_WIDTH-1:DIV_STEPS];
         low_ff[0]  <= numer[DIV_STEPS-1:0];
         quo_ff[0]  <= '0;
         peak_ff[0] <= peak;
         norm_ff[0] <= norm;
         pass_ff[0] <= level[LEVEL_WIDTH-1:0];
      end
   end

   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
      logic [SCALED_WIDTH:0]   trial;
      logic [SCALED_WIDTH:0]   diff;
      logic                    take;
      logic [SCALED_WIDTH-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[j-1], low_ff[j-1][DIV_STEPS-1]};
         diff   = trial - {1'b0, peak_ff[j-1]};
         take   = trial >= {1'b0, peak_ff[j-1]};
         rem_in = take ? diff[SCALED_WIDTH-1:0] : trial[SCALED_WIDTH-1:0];
      end

      always_ff @(posedge clock) begin
         if (load[j]) begin
            rem_ff[j]  <= rem_in;
            low_ff[j]  <= {low_ff[j-1][DIV_STEPS-2:0], 1'b0};
            quo_ff[j]  <= {quo_ff[j-1][DIV_STEPS-2:0], take};
            peak_ff[j] <= peak_ff[j-1];
            norm_ff[j] <= norm_ff[j-1];
            pass_ff[j] <= pass_ff[j-1];
         end
      end
   end

   assign level_out = norm_ff[DIV_STEPS] ? LEVEL_WIDTH'(quo_ff[DIV_STEPS])
                                         : pass_ff[DIV_STEPS];

endmodule

// ----- design/lca_luma.sv -----
// Merging stage that forms the weighted luminance of the three lanes.
module lca_luma (
   input  logic                            clock,
   input  logic [1:0]                      load,
   input  lca_pkg::csr_type                csr,
   input  logic [lca_pkg::LEVEL_WIDTH-1:0] level [lca_pkg::NUM_LANES],
   output logic [lca_pkg::LEVEL_WIDTH-1:0] level_out [lca_pkg::NUM_LANES],
   output logic [lca_pkg::LUMA_WIDTH-1:0]  luma
);
   import lca_pkg::*;

   localparam int WPROD_W = LEVEL_WIDTH + CSR_WIDTH;
   localparam int WSUM_W  = WPROD_W + 2;

   logic [CSR_WIDTH-1:0]   weight  [NUM_LANES];
   logic [WPROD_W-1:0]     prod_ff [NUM_LANES];
   logic [LEVEL_WIDTH-1:0] lvl_a_ff [NUM_LANES];
   logic [LEVEL_WIDTH-1:0] lvl_b_ff [NUM_LANES];
   logic [WSUM_W-1:0]      sum;
   logic [LUMA_WIDTH-1:0]  luma_ff;

   assign weight[0] = csr.luma_weight_r;
   assign weight[1] = csr.luma_weight_g;
   assign weight[2] = csr.luma_weight_b;

   assign sum = WSUM_W'(prod_ff[0]) + WSUM_W'(prod_ff[1]) + WSUM_W'(prod_ff[2]);

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_LANES; i++) begin
         if (load[0]) begin
            prod_ff[i]  <= level[i] * weight[i];
            lvl_a_ff[i] <= level[i];
         end
         if (load[1]) begin
            lvl_b_ff[i] <= lvl_a_ff[i];
         end
      end
      if (load[1]) begin
         luma_ff <= sum[WSUM_W-1:CSR_WIDTH];
      end
   end

   assign level_out = lvl_b_ff;
   assign luma      = luma_ff;

endmodule

// ----- design/lca_sat_lane.sv -----
// One channel lane: saturation around the luminance and conversion to a clamped byte.
module lca_sat_lane (
   input  logic                            clock,
   input  logic [1:0]                      load,
   input  logic [lca_pkg::LEVEL_WIDTH-1:0] level,
   input  logic [lca_pkg::LUMA_WIDTH-1:0]  luma,
   input  logic [lca_pkg::CSR_WIDTH-1:0]   sat,
   output logic [7:0]                      byte_out
);
   import lca_pkg::*;

   localparam int DIFF_W = LUMA_WIDTH + 1;
   localparam int MUL_W  = DIFF_W + CSR_WIDTH + 1;

   logic signed [DIFF_W-1:0] diff;
   logic signed [MUL_W-1:0]  prod_in;
   logic signed [MUL_W-1:0]  prod_ff;
   logic [LUMA_WIDTH-1:0]    luma_ff;
   logic signed [MUL_W-1:0]  final_level;
   logic [7:0]               byte_in;
   logic [7:0]               byte_ff;

   always_comb begin
      diff        = $signed({{(DIFF_W - LEVEL_WIDTH){1'b0}}, level}) - $signed({1'b0, luma});
      prod_in     = diff * $signed({1'b0, sat});
      final_level = MUL_W'($signed({1'b0, luma_ff})) + (prod_ff >>> FRAC_BITS);
      if (final_level[MUL_W-1]) begin
         byte_in = 8'h00;
      end else if (|final_level[MUL_W-2:2*FRAC_BITS]) begin
         byte_in = 8'hFF;
      end else begin
         byte_in = final_level[2*FRAC_BITS-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         prod_ff <= prod_in;
         luma_ff <= luma;
      end
      if (load[1]) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

// ----- design/lightmap_color_adjust.sv -----
// Top level of the lightmap color adjust block: control pipeline, registers and lanes.
//
// Adjusts one lightmap texel per item: offset and gain per channel, scaling of all
// three channels down to 255 when the brightest exceeds it, saturation around the
// luminance, and conversion to three bytes. The three channels run in parallel lanes.
// A new item is taken every cycle while the input is not stalled. In the divider lanes, a
// stage forms the scaled numerator and 16 further stages each produce one quotient bit.
// The stages advance independently, so bubbles close up and the input is stalled only
// when every stage holds an item and the result side stalls. Registers are written
// through the APB-style port at byte address 4 times the register index.
`include "lightmap_color_adjust_defines.svh"

module lightmap_color_adjust (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lca_pkg::req_payload_type             req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lca_pkg::rsp_payload_type             rsp_payload,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lca_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [lca_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [lca_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);
   import lca_pkg::*;

   localparam int DIV_FIRST  = 1;
   localparam int LUMA_FIRST = DIV_FIRST + DIV_STEPS + 1;
   localparam int SAT_FIRST  = LUMA_FIRST + 2;
   localparam int NSTAGE     = SAT_FIRST + 2;

   csr_type csr_ff;
   csr_type csr_in;
   logic    csr_write;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] adv;

   logic [CHANNEL_WIDTH-1:0] chan      [NUM_LANES];
   logic [SCALED_WIDTH-1:0]  scaled    [NUM_LANES];
   logic [LEVEL_WIDTH-1:0]   normed    [NUM_LANES];
   logic [LEVEL_WIDTH-1:0]   luma_lvl  [NUM_LANES];
   logic [7:0]               byte_lane [NUM_LANES];
   logic [LUMA_WIDTH-1:0]    luma;
   logic [SCALED_WIDTH-1:0]  peak_rg;
   logic [SCALED_WIDTH-1:0]  peak;
   logic                     norm;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         case (paddr[CSR_ADDR_WIDTH-1:2])
            IDX_ADD_OFFSET:    csr_in.add_offset    = $signed(pwdata[CSR_WIDTH-1:0]);
            IDX_GAIN:          csr_in.gain          = pwdata[CSR_WIDTH-1:0];
            IDX_SAT_FACTOR:    csr_in.sat_factor    = pwdata[CSR_WIDTH-1:0];
            IDX_LUMA_WEIGHT_R: csr_in.luma_weight_r = pwdata[CSR_WIDTH-1:0];
            IDX_LUMA_WEIGHT_G: csr_in.luma_weight_g = pwdata[CSR_WIDTH-1:0];
            IDX_LUMA_WEIGHT_B: csr_in.luma_weight_b = pwdata[CSR_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[CSR_ADDR_WIDTH-1:2])
         IDX_ADD_OFFSET:    prdata = CSR_DATA_WIDTH'(unsigned'(csr_ff.add_offset));
         IDX_GAIN:          prdata = CSR_DATA_WIDTH'(csr_ff.gain);
         IDX_SAT_FACTOR:    prdata = CSR_DATA_WIDTH'(csr_ff.sat_factor);
         IDX_LUMA_WEIGHT_R: prdata = CSR_DATA_WIDTH'(csr_ff.luma_weight_r);
         IDX_LUMA_WEIGHT_G: prdata = CSR_DATA_WIDTH'(csr_ff.luma_weight_g);
         IDX_LUMA_WEIGHT_B: prdata = CSR_DATA_WIDTH'(csr_ff.luma_weight_b);
         default:           prdata = '0;
      endcase
   end

   assign adv[NSTAGE-1] = !valid_ff[NSTAGE-1] || !rsp_stall;
   for (genvar k = 0; k < NSTAGE - 1; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end

   always_comb begin
      valid_in[0] = adv[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff             <= '0;
         csr_ff.add_offset    <= $signed(RST_ADD_OFFSET);
         csr_ff.gain          <= RST_GAIN;
         csr_ff.sat_factor    <= RST_SAT_FACTOR;
         csr_ff.luma_weight_r <= RST_LUMA_WEIGHT_R;
         csr_ff.luma_weight_g <= RST_LUMA_WEIGHT_G;
         csr_ff.luma_weight_b <= RST_LUMA_WEIGHT_B;
      end else begin
         valid_ff <= valid_in;
         csr_ff   <= csr_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[NSTAGE-1];

   assign chan[0] = req_payload.red_in;
   assign chan[1] = req_payload.green_in;
   assign chan[2] = req_payload.blue_in;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_front
      lca_scale_lane u_scale (
         .clock     (clock),
         .load      (adv[0]),
         .chan      (chan[i]),
         .offset    (csr_ff.add_offset),
         .gain      (csr_ff.gain),
         .level_out (scaled[i])
      );
   end

   always_comb begin
      peak_rg = (scaled[0] > scaled[1]) ? scaled[0] : scaled[1];
      peak    = (scaled[2] > peak_rg) ? scaled[2] : peak_rg;
      norm    = peak > SCALED_WIDTH'(NORM_LIMIT);
   end

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_div
      lca_div_lane u_div (
         .clock     (clock),
         .load      (adv[DIV_FIRST+DIV_STEPS:DIV_FIRST]),
         .level     (scaled[i]),
         .peak      (peak),
         .norm      (norm),
         .level_out (normed[i])
      );
   end

   lca_luma u_luma (
      .clock     (clock),
      .load      (adv[LUMA_FIRST+1:LUMA_FIRST]),
      .csr       (csr_ff),
      .level     (normed),
      .level_out (luma_lvl),
      .luma      (luma)
   );

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_sat
      lca_sat_lane u_sat (
         .clock    (clock),
         .load     (adv[SAT_FIRST+1:SAT_FIRST]),
         .level    (luma_lvl[i]),
         .luma     (luma),
         .sat      (csr_ff.sat_factor),
         .byte_out (byte_lane[i])
      );
   end

   assign rsp_payload.red_out   = byte_lane[0];
   assign rsp_payload.green_out = byte_lane[1];
   assign rsp_payload.blue_out  = byte_lane[2];

   `LCA_ASSERT_IMPL(a_stall_only_when_full, clock, reset, req_stall, &valid_ff)
   `LCA_ASSERT_NEXT(a_accept_enters_pipe, clock, reset, req_valid && !req_stall, valid_ff[0])
   `LCA_ASSERT_NEXT(a_no_repeat, clock, reset, rsp_valid && !rsp_stall && !valid_ff[NSTAGE-2], !rsp_valid)

endmodule

// ----- tb/lightmap_color_adjust_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the lightmap color adjust block with its own texel predictor.
module lightmap_color_adjust_test;
   import lca_pkg::*;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned LONG_HOLD = 200;
   localparam int unsigned SETTLE_CYCLES = 30;
   localparam int unsigned RANDOM_PHASES = 12;
   localparam int unsigned PHASE_TEXELS = 100;
   localparam logic [2:0] UNMAPPED_INDEX_LO = 3'd6;
   localparam logic [2:0] UNMAPPED_INDEX_HI = 3'd7;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_payload_type rsp_payload;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   logic signed [15:0] cfg_add_offset;
   logic [15:0] cfg_gain;
   logic [15:0] cfg_sat_factor;
   logic [15:0] cfg_weight_r;
   logic [15:0] cfg_weight_g;
   logic [15:0] cfg_weight_b;

   rsp_payload_type pending_bytes[$];
   int error_count = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit long_hold_req = 1'b0;

   lightmap_color_adjust u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic rsp_payload_type adjust_texel(req_payload_type texel);
      longint level[3];
      longint peak;
      longint luma;
      longint byte_val;
      rsp_payload_type result;
      level[0] = longint'(texel.red_in);
      level[1] = longint'(texel.green_in);
      level[2] = longint'(texel.blue_in);
      for (int i = 0; i < 3; i++) begin
         level[i] = ((level[i] + longint'(cfg_add_offset)) * longint'(cfg_gain)) >>> 8;
         if (level[i] < 0) begin
            level[i] = 0;
         end
      end
      peak = level[1];
      if (level[0] > peak) begin
         peak = level[0];
      end
      if (level[2] > peak) begin
         peak = level[2];
      end
      if (peak > 65280) begin
         for (int i = 0; i < 3; i++) begin
            level[i] = (level[i] * 65280) / peak;
         end
      end
      if (cfg_sat_factor != 16'd256) begin
         luma = (level[0] * longint'(cfg_weight_r) + level[1] * longint'(cfg_weight_g)
                 + level[2] * longint'(cfg_weight_b)) >>> 16;
         for (int i = 0; i < 3; i++) begin
            level[i] = luma + (((level[i] - luma) * longint'(cfg_sat_factor)) >>> 8);
         end
      end
      for (int i = 0; i < 3; i++) begin
         byte_val = level[i] >>> 8;
         if (byte_val < 0) begin
            byte_val = 0;
         end
         if (byte_val > 255) begin
            byte_val = 255;
         end
         level[i] = byte_val;
      end
      result.red_out = level[0][7:0];
      result.green_out = level[1][7:0];
      result.blue_out = level[2][7:0];
      return result;
   endfunction

   function automatic logic [15:0] shadow_value(logic [2:0] index);
      case (index)
         IDX_ADD_OFFSET: return cfg_add_offset;
         IDX_GAIN: return cfg_gain;
         IDX_SAT_FACTOR: return cfg_sat_factor;
         IDX_LUMA_WEIGHT_R: return cfg_weight_r;
         IDX_LUMA_WEIGHT_G: return cfg_weight_g;
         IDX_LUMA_WEIGHT_B: return cfg_weight_b;
         default: return 16'd0;
      endcase
   endfunction

   task automatic write_register(logic [2:0] index, logic [15:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         IDX_ADD_OFFSET: cfg_add_offset = value;
         IDX_GAIN: cfg_gain = value;
         IDX_SAT_FACTOR: cfg_sat_factor = value;
         IDX_LUMA_WEIGHT_R: cfg_weight_r = value;
         IDX_LUMA_WEIGHT_G: cfg_weight_g = value;
         IDX_LUMA_WEIGHT_B: cfg_weight_b = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic check_register(logic [2:0] index);
      logic [CSR_DATA_WIDTH-1:0] read_val;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      read_val = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (read_val[15:0] !== shadow_value(index)) begin
         $error("register %0d: expected %0d, got %0d", index, shadow_value(index),
                read_val[15:0]);
         error_count++;
      end
      @(posedge clock);
   endtask

   task automatic send_texel(req_payload_type texel);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= texel;
      do @(posedge clock); while (req_stall);
      pending_bytes.push_back(adjust_texel(texel));
   endtask

   task automatic send_rgb(logic [23:0] red, logic [23:0] green, logic [23:0] blue);
      req_payload_type texel;
      texel.red_in = red;
      texel.green_in = green;
      texel.blue_in = blue;
      send_texel(texel);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() != 0);
   endtask

   function automatic logic [23:0] random_level(int unsigned mode);
      case (mode)
         0: return 24'($urandom);
         1: return 24'($urandom_range(0, 24'h01FFFF));
         2: return 24'($urandom_range(0, 24'h000FFF));
         default: return 24'($urandom_range(24'h00FD00, 24'h010100));
      endcase
   endfunction

   function automatic req_payload_type random_texel();
      req_payload_type texel;
      int unsigned mode;
      mode = $urandom_range(0, 4);
      if (mode == 4) begin
         texel.red_in = random_level($urandom_range(0, 3));
         texel.green_in = random_level($urandom_range(0, 3));
         texel.blue_in = random_level($urandom_range(0, 3));
      end else begin
         texel.red_in = random_level(mode);
         texel.green_in = random_level(mode);
         texel.blue_in = random_level(mode);
      end
      return texel;
   endfunction

   function automatic logic [15:0] random_weight(int unsigned mode, logic [15:0] typical);
      case (mode)
         0: return typical;
         1: return 16'($urandom_range(0, 21845));
         2: return 16'($urandom);
         default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   task automatic load_random_settings();
      logic [15:0] value;
      int unsigned weight_mode;
      case ($urandom_range(0, 3))
         0: value = 16'h0000;
         1: value = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         2: value = 16'($signed(12'($urandom)));
         default: value = 16'($urandom);
      endcase
      write_register(IDX_ADD_OFFSET, value);
      case ($urandom_range(0, 3))
         0: value = 16'd256;
         1: value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         2: value = 16'($urandom_range(128, 1024));
         default: value = 16'($urandom);
      endcase
      write_register(IDX_GAIN, value);
      case ($urandom_range(0, 3))
         0: value = 16'd256;
         1: value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         2: value = 16'($urandom_range(0, 512));
         default: value = 16'($urandom);
      endcase
      write_register(IDX_SAT_FACTOR, value);
      weight_mode = $urandom_range(0, 3);
      write_register(IDX_LUMA_WEIGHT_R, random_weight(weight_mode, RST_LUMA_WEIGHT_R));
      write_register(IDX_LUMA_WEIGHT_G, random_weight(weight_mode, RST_LUMA_WEIGHT_G));
      write_register(IDX_LUMA_WEIGHT_B, random_weight(weight_mode, RST_LUMA_WEIGHT_B));
   endtask

   task automatic test_reset_defaults();
      send_rgb(24'h000000, 24'h000000, 24'h000000);
      send_rgb(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_rgb(24'h00FF00, 24'h008000, 24'h000100);
      send_rgb(24'h00FF00, 24'h00FF01, 24'h000000);
      send_rgb(24'hFFFFFF, 24'h000000, 24'h000001);
      send_rgb(24'hAAAAAA, 24'h555555, 24'h0000FF);
      wait_for_results();
   endtask

   task automatic test_register_access();
      logic [2:0] index;
      for (int i = 0; i < NUM_LANES * 2; i++) begin
         index = 3'(i);
         write_register(index, 16'($urandom));
      end
      write_register(UNMAPPED_INDEX_LO, 16'($urandom));
      write_register(UNMAPPED_INDEX_HI, 16'($urandom));
      for (int i = 0; i < NUM_LANES * 2; i++) begin
         index = 3'(i);
         check_register(index);
      end
      send_texel(random_texel());
      send_texel(random_texel());
      wait_for_results();
   endtask

   task automatic test_special_cases();
      write_register(IDX_ADD_OFFSET, 16'h8000);
      write_register(IDX_GAIN, RST_GAIN);
      write_register(IDX_SAT_FACTOR, RST_SAT_FACTOR);
      write_register(IDX_LUMA_WEIGHT_R, RST_LUMA_WEIGHT_R);
      write_register(IDX_LUMA_WEIGHT_G, RST_LUMA_WEIGHT_G);
      write_register(IDX_LUMA_WEIGHT_B, RST_LUMA_WEIGHT_B);
      send_rgb(24'h000100, 24'h007FFF, 24'h00FFFF);
      send_rgb(24'h008000, 24'h000000, 24'hFFFFFF);
      wait_for_results();
      write_register(IDX_ADD_OFFSET, 16'h7FFF);
      write_register(IDX_GAIN, 16'hFFFF);
      send_rgb(24'h000000, 24'h000000, 24'h000000);
      send_rgb(24'h100000, 24'h000000, 24'h000001);
      wait_for_results();
      write_register(IDX_GAIN, 16'h0000);
      send_rgb(24'hFFFFFF, 24'h7FFFFF, 24'h00FF00);
      wait_for_results();
      write_register(IDX_ADD_OFFSET, RST_ADD_OFFSET);
      write_register(IDX_GAIN, RST_GAIN);
      write_register(IDX_SAT_FACTOR, 16'hFFFF);
      send_rgb(24'h00FF00, 24'h000000, 24'h000000);
      send_rgb(24'h001000, 24'h00F000, 24'h008000);
      wait_for_results();
      write_register(IDX_SAT_FACTOR, 16'h0000);
      write_register(IDX_LUMA_WEIGHT_R, 16'hFFFF);
      write_register(IDX_LUMA_WEIGHT_G, 16'hFFFF);
      write_register(IDX_LUMA_WEIGHT_B, 16'hFFFF);
      send_rgb(24'h00FF00, 24'h00FF00, 24'h00FF00);
      wait_for_results();
      write_register(IDX_LUMA_WEIGHT_R, 16'h0000);
      write_register(IDX_LUMA_WEIGHT_G, 16'h0000);
      write_register(IDX_LUMA_WEIGHT_B, 16'h0000);
      send_rgb(24'h00FF00, 24'h001234, 24'h00ABCD);
      wait_for_results();
      write_register(IDX_SAT_FACTOR, 16'd512);
      write_register(IDX_LUMA_WEIGHT_R, RST_LUMA_WEIGHT_R);
      write_register(IDX_LUMA_WEIGHT_G, RST_LUMA_WEIGHT_G);
      write_register(IDX_LUMA_WEIGHT_B, RST_LUMA_WEIGHT_B);
      send_rgb(24'h00C000, 24'h004000, 24'h002000);
      wait_for_results();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_random_settings();
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_TEXELS; n++) begin
            send_texel(random_texel());
         end
         wait_for_results();
      end
   endtask

   task automatic test_backpressure();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      long_hold_req = 1'b1;
      for (int n = 0; n < 80; n++) begin
         send_texel(random_texel());
      end
      wait_for_results();
   endtask

   task automatic test_full_rate();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int n = 0; n < PHASE_TEXELS; n++) begin
         send_texel(random_texel());
      end
      wait_for_results();
   endtask

   initial begin : result_sink
      int unsigned hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         hold = rsp_idle_on ? $urandom_range(0, 13) : 0;
         if (long_hold_req) begin
            hold = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            $error("result item arrived with none expected");
            error_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_payload.red_out !== want.red_out) begin
               $error("red_out: expected %0d, got %0d", want.red_out, rsp_payload.red_out);
               error_count++;
            end
            if (rsp_payload.green_out !== want.green_out) begin
               $error("green_out: expected %0d, got %0d", want.green_out,
                      rsp_payload.green_out);
               error_count++;
            end
            if (rsp_payload.blue_out !== want.blue_out) begin
               $error("blue_out: expected %0d, got %0d", want.blue_out, rsp_payload.blue_out);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      cfg_add_offset = RST_ADD_OFFSET;
      cfg_gain = RST_GAIN;
      cfg_sat_factor = RST_SAT_FACTOR;
      cfg_weight_r = RST_LUMA_WEIGHT_R;
      cfg_weight_g = RST_LUMA_WEIGHT_G;
      cfg_weight_b = RST_LUMA_WEIGHT_B;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_access();
      test_special_cases();
      test_random_settings();
      test_backpressure();
      test_full_rate();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_bytes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
